>>> rtl/ffpa_pkg.sv
package ffpa_pkg;

  // Operation codes carried in the func field
  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_e;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LAUNCH,
    ST_SCAN,
    ST_PREP,
    ST_COMMIT
  } state_e;

  localparam int SIZE_W = 16;
  localparam int ADDR_W = 16;

  // Run length in bytes, saturated at 64 KiB so it always covers any request
  localparam int                RUN_W   = SIZE_W + 1;
  localparam logic [RUN_W-1:0]  RUN_CAP = RUN_W'(65536);

  typedef struct packed {
    logic              func;
    logic [SIZE_W-1:0] size_bytes;
    logic [ADDR_W-1:0] address;
  } in_item_t;

  typedef struct packed {
    logic              status;
    logic [ADDR_W-1:0] block_offset;
    logic [SIZE_W-1:0] freed_bytes;
  } out_item_t;

  // Scan token handed from cell to cell
  typedef struct packed {
    logic             valid;
    logic             found;
    logic [RUN_W-1:0] run_bytes;
  } wave_t;

  // Broadcast from the controller to every cell
  typedef struct packed {
    logic commit;
    op_e  op;
  } ctl_t;

endpackage

>>> rtl/ffpa_cell.sv
module ffpa_cell #(
  parameter int PAGE_BYTES = 256,
  parameter int PAGE_TOTAL = 256,
  parameter int IDX        = 0
) (
  input  logic                                                     clk,
  input  logic                                                     rst_n,
  input  ffpa_pkg::ctl_t                                           ctl,
  input  logic [ffpa_pkg::SIZE_W-1:0]                              req_size,
  input  logic [ffpa_pkg::ADDR_W-1:0]                              req_addr,
  input  logic [$clog2(PAGE_TOTAL)-1:0]                            base_idx,
  input  logic [(($clog2(PAGE_TOTAL*PAGE_BYTES) > 16) ?
                 $clog2(PAGE_TOTAL*PAGE_BYTES) : 16):0]            end_off,
  input  ffpa_pkg::wave_t                                          wave_in,
  input  logic [$clog2(PAGE_TOTAL)-1:0]                            idx_in,
  output ffpa_pkg::wave_t                                          wave_out,
  output logic [$clog2(PAGE_TOTAL)-1:0]                            idx_out
);
  import ffpa_pkg::*;

  localparam int PW = $clog2(PAGE_TOTAL);
  localparam int OW = $clog2(PAGE_TOTAL * PAGE_BYTES);
  localparam int CW = (OW > 16) ? OW : 16;
  localparam int EW = CW + 1;

  localparam logic [PW-1:0]    MY_IDX  = PW'(IDX);
  localparam logic [CW-1:0]    MY_OFF  = CW'(IDX * PAGE_BYTES);
  localparam logic [RUN_W:0]   PB_RUN  = (RUN_W + 1)'(PAGE_BYTES);

  logic            used_r, used_nxt;
  logic            start_r, start_nxt;
  wave_t           wave_r, wave_nxt;
  logic [PW-1:0]   idx_r, idx_nxt;

  logic [RUN_W:0]   run_sum;
  logic [RUN_W-1:0] run_sat;
  logic             in_range;
  logic             is_base;

  assign run_sum = {1'b0, wave_in.run_bytes} + PB_RUN;
  assign run_sat = (run_sum > {1'b0, RUN_CAP}) ? RUN_CAP : run_sum[RUN_W-1:0];

  // Advance the scan token one page
  always_comb begin
    wave_nxt = wave_in;
    idx_nxt  = idx_in;
    if (wave_in.valid && !wave_in.found) begin
      case (ctl.op)
        OP_ALLOC: begin
          if (used_r) begin
            wave_nxt.run_bytes = '0;
          end else begin
            if (wave_in.run_bytes == '0) begin
              idx_nxt = MY_IDX;
            end
            wave_nxt.run_bytes = run_sat;
            if (run_sat >= {1'b0, req_size}) begin
              wave_nxt.found = 1'b1;
            end
          end
        end
        OP_FREE: begin
          if (start_r && (MY_OFF == CW'(req_addr))) begin
            wave_nxt.found = 1'b1;
            idx_nxt        = MY_IDX;
          end
        end
        default: ;
      endcase
    end
  end

  assign in_range = (MY_IDX >= base_idx) && (EW'(MY_OFF) < end_off);
  assign is_base  = (MY_IDX == base_idx);

  // Mark or release the page when the block covers it
  always_comb begin
    used_nxt  = used_r;
    start_nxt = start_r;
    if (ctl.commit) begin
      if (in_range) begin
        used_nxt = (ctl.op == OP_ALLOC);
      end
      if (is_base) begin
        start_nxt = (ctl.op == OP_ALLOC);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r  <= (IDX == 0);
      start_r <= 1'b0;
      wave_r  <= '0;
    end else begin
      used_r  <= used_nxt;
      start_r <= start_nxt;
      wave_r  <= wave_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
  end

  assign wave_out = wave_r;
  assign idx_out  = idx_r;

endmodule

>>> rtl/first_fit_page_allocator.sv
// Requests are handled one at a time: a new beat is accepted only in the idle
//   state. Each request launches a scan token that walks the page cell chain one
//   page per cycle; an allocate of zero bytes bypasses the scan and goes straight
//   to the commit state. The result is loaded once the result register is free.
// Reset: synchronous, active low; all pages free except page 0, no live blocks.
//   The block size store is not cleared and needs no clearing pass.
module first_fit_page_allocator #(
  parameter int PAGE_BYTES = 256,
  parameter int PAGE_TOTAL = 256
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  ffpa_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output ffpa_pkg::out_item_t out_data
);
  import ffpa_pkg::*;

  localparam int PW = $clog2(PAGE_TOTAL);
  localparam int OW = $clog2(PAGE_TOTAL * PAGE_BYTES);
  localparam int CW = (OW > 16) ? OW : 16;
  localparam int EW = CW + 1;

  localparam logic [OW-1:0] PB_OFF = OW'(PAGE_BYTES);

  // Controller state
  state_e           state_r, state_nxt;
  in_item_t         req_r;
  logic             found_r;
  logic [PW-1:0]    idx_r;
  logic [OW-1:0]    base_off_r;
  logic [SIZE_W-1:0] rd_r;
  logic             out_valid_r;
  out_item_t        out_data_r;

  // Block size store, one entry per page, written at a block's start page
  logic [SIZE_W-1:0] block_bytes_mem [PAGE_TOTAL];

  // Cell chain wiring
  wave_t         wave_w [PAGE_TOTAL+1];
  logic [PW-1:0] idx_w  [PAGE_TOTAL+1];
  ctl_t          ctl;

  logic          in_fire;
  logic          out_free;
  logic          out_load;
  logic          mem_we;
  logic          zero_alloc;
  op_e           req_op;
  logic [SIZE_W-1:0] commit_bytes;
  logic [EW-1:0]     end_off;

  assign req_op     = op_e'(req_r.func);
  assign in_fire    = in_valid && in_ready;
  assign zero_alloc = (op_e'(in_data.func) == OP_ALLOC) && (in_data.size_bytes == '0);
  assign out_free   = !out_valid_r || out_ready;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          // Zero-size allocate fails without touching the pool
          state_nxt = zero_alloc ? ST_COMMIT : ST_LAUNCH;
        end
      end
      ST_LAUNCH: begin
        state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        // Token leaves the last cell: the search result is final
        if (wave_w[PAGE_TOTAL].valid) begin
          state_nxt = ST_PREP;
        end
      end
      ST_PREP: begin
        state_nxt = ST_COMMIT;
      end
      ST_COMMIT: begin
        // Hold until the result register is free
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control outputs
  always_comb begin
    in_ready   = 1'b0;
    out_load   = 1'b0;
    ctl.commit = 1'b0;
    ctl.op     = req_op;
    mem_we     = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
      end
      ST_COMMIT: begin
        out_load   = out_free;
        ctl.commit = out_free && found_r;
        mem_we     = out_free && found_r && (req_op == OP_ALLOC);
      end
      default: ;
    endcase
  end

  // Inject the token at page 0, which always reads as used
  assign wave_w[0] = '{valid: (state_r == ST_LAUNCH), found: 1'b0, run_bytes: '0};
  assign idx_w[0]  = '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Request capture and search result
  always_ff @(posedge clk) begin
    if (in_fire) begin
      req_r   <= in_data;
      found_r <= 1'b0;
    end else if (state_r == ST_SCAN && wave_w[PAGE_TOTAL].valid) begin
      found_r <= wave_w[PAGE_TOTAL].found;
      idx_r   <= idx_w[PAGE_TOTAL];
    end
    if (state_r == ST_PREP) begin
      base_off_r <= OW'(idx_r) * PB_OFF;
    end
  end

  // Registered read; idx_r holds from prep through commit
  always_ff @(posedge clk) begin
    if (mem_we) begin
      block_bytes_mem[idx_r] <= req_r.size_bytes;
    end
    rd_r <= block_bytes_mem[idx_r];
  end

  // Byte span of the block being marked or released
  assign commit_bytes = (req_op == OP_ALLOC) ? req_r.size_bytes : rd_r;
  assign end_off      = EW'(base_off_r) + EW'(commit_bytes);

  // Page cells
  for (genvar g = 0; g < PAGE_TOTAL; g++) begin : g_cell
    ffpa_cell #(
      .PAGE_BYTES (PAGE_BYTES),
      .PAGE_TOTAL (PAGE_TOTAL),
      .IDX        (g)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctl      (ctl),
      .req_size (req_r.size_bytes),
      .req_addr (req_r.address),
      .base_idx (idx_r),
      .end_off  (end_off),
      .wave_in  (wave_w[g]),
      .idx_in   (idx_w[g]),
      .wave_out (wave_w[g+1]),
      .idx_out  (idx_w[g+1])
    );
  end

  // Result register parts the scan from the output handshake
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r.status       <= !found_r;
      out_data_r.block_offset <= (found_r && req_op == OP_ALLOC) ?
                                 ADDR_W'(base_off_r) : '0;
      out_data_r.freed_bytes  <= (found_r && req_op == OP_FREE) ? rd_r : '0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  a_tail_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    wave_w[PAGE_TOTAL].valid |-> state_r == ST_SCAN)
    else $error("scan token left the chain outside the scan state");

  a_commit_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_COMMIT && out_valid_r && !out_ready) |=>
      (state_r == ST_COMMIT && $stable(out_data_r)))
    else $error("result overwritten while the previous beat was stalled");

  a_alloc_not_page0: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.commit |-> idx_r != '0)
    else $error("commit aimed at the reserved page");

  a_result_from_commit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == ST_COMMIT)
    else $error("result raised outside the commit state");
`endif

endmodule
